// ===== rtl/core/koqt_pkg.sv =====
// Shared types and constants for the keyed ordered queue table.
// Holds opcode and status codes and the control struct broadcast to the cells.
// No dependencies.
package koqt_pkg;

    localparam int CAPACITY  = 16;
    localparam int DATA_BITS = 32;
    localparam int ID_BITS   = 16;
    localparam int OP_BITS   = 4;
    localparam int ST_BITS   = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_PUSH      = 4'd0,
        OP_PUSH_ID   = 4'd1,
        OP_PEEK      = 4'd2,
        OP_POP_FIRST = 4'd3,
        OP_POP_LAST  = 4'd4,
        OP_NEXT      = 4'd5,
        OP_DEL_ID    = 4'd6,
        OP_DEL_DATA  = 4'd7,
        OP_MODIFY    = 4'd8,
        OP_SEARCH    = 4'd9,
        OP_CLEAR     = 4'd10
    } t_op;

    typedef enum logic [ST_BITS-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic en;
        logic match_all;
        logic match_id;
        logic match_data;
        logic match_tail;
        logic report_next;
        logic do_remove;
        logic do_push;
        logic do_modify;
        logic do_clear;
    } t_ctrl;

endpackage

// ===== rtl/core/keyed_ordered_queue_table.sv =====
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one operation per cycle while results are taken; every operation finishes in a single
// pass through the row of CAPACITY slot cells (parallel match, shift to close gaps).
// A result waiting in the output register does not stall input if it is taken.
// Reset empties the table, zeroes the id counter and drops any pending result.
// Top level of the keyed ordered queue table; depends on koqt_pkg and koqt_cell.
module keyed_ordered_queue_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [koqt_pkg::OP_BITS-1:0]     i_opcode,
    input  logic [koqt_pkg::ID_BITS-1:0]     i_id_in,
    input  logic [koqt_pkg::DATA_BITS-1:0]   i_data_in,
    input  logic                             i_from_start,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [koqt_pkg::ST_BITS-1:0]     o_status,
    output logic [koqt_pkg::ID_BITS-1:0]     o_id_out,
    output logic [koqt_pkg::DATA_BITS-1:0]   o_data_out
);
    import koqt_pkg::*;

    logic                 w_accept;
    t_op                  w_op;
    t_ctrl                w_ctrl;
    logic                 w_empty;
    logic                 w_full;
    logic [ID_BITS-1:0]   w_push_id;

    logic [CAPACITY-1:0]  w_valid;
    logic [CAPACITY-1:0]  w_hit;
    logic [CAPACITY-1:0]  w_first;
    logic [CAPACITY-1:0]  w_report;
    logic [ID_BITS-1:0]   w_id   [CAPACITY];
    logic [DATA_BITS-1:0] w_data [CAPACITY];

    logic                 w_found;
    logic [ID_BITS-1:0]   w_sel_id;
    logic [DATA_BITS-1:0] w_sel_data;

    logic [ID_BITS-1:0]   r_id_ctr;
    logic [ID_BITS-1:0]   n_id_ctr;
    logic                 r_out_valid;
    t_status              r_status;
    logic [ID_BITS-1:0]   r_id_out;
    logic [DATA_BITS-1:0] r_data_out;
    t_status              n_status;
    logic [ID_BITS-1:0]   n_id_out;
    logic [DATA_BITS-1:0] n_data_out;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_op        = t_op'(i_opcode);
    assign w_empty     = !w_valid[0];
    assign w_full      = w_valid[CAPACITY-1];
    assign n_id_ctr    = r_id_ctr + ID_BITS'(1);
    assign w_push_id   = (w_op == OP_PUSH) ? n_id_ctr : i_id_in;

    always_comb begin
        w_ctrl    = '0;
        w_ctrl.en = w_accept;
        unique case (w_op)
            OP_PUSH, OP_PUSH_ID: w_ctrl.do_push = !w_full;
            OP_PEEK:             w_ctrl.match_all = 1'b1;
            OP_POP_FIRST: begin
                w_ctrl.match_all = 1'b1;
                w_ctrl.do_remove = 1'b1;
            end
            OP_POP_LAST: begin
                w_ctrl.match_tail = 1'b1;
                w_ctrl.do_remove  = 1'b1;
            end
            OP_NEXT: begin
                w_ctrl.match_all   = i_from_start;
                w_ctrl.match_data  = !i_from_start;
                w_ctrl.report_next = !i_from_start;
            end
            OP_DEL_ID: begin
                w_ctrl.match_id  = 1'b1;
                w_ctrl.do_remove = 1'b1;
            end
            OP_DEL_DATA: begin
                w_ctrl.match_data = 1'b1;
                w_ctrl.do_remove  = 1'b1;
            end
            OP_MODIFY: begin
                w_ctrl.match_id  = 1'b1;
                w_ctrl.do_modify = 1'b1;
            end
            OP_SEARCH:           w_ctrl.match_id = 1'b1;
            OP_CLEAR:            w_ctrl.do_clear = 1'b1;
            default:             w_ctrl.en = w_accept;
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                 w_prev_valid;
        logic                 w_prev_hit;
        logic                 w_prev_first;
        logic                 w_next_valid;
        logic [ID_BITS-1:0]   w_next_id;
        logic [DATA_BITS-1:0] w_next_data;

        if (g == 0) begin : g_head
            assign w_prev_valid = 1'b1;
            assign w_prev_hit   = 1'b0;
            assign w_prev_first = 1'b0;
        end else begin : g_body
            assign w_prev_valid = w_valid[g-1];
            assign w_prev_hit   = w_hit[g-1];
            assign w_prev_first = w_first[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_valid = 1'b0;
            assign w_next_id    = '0;
            assign w_next_data  = '0;
        end else begin : g_link
            assign w_next_valid = w_valid[g+1];
            assign w_next_id    = w_id[g+1];
            assign w_next_data  = w_data[g+1];
        end

        koqt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_key_id     (i_id_in),
            .i_key_data   (i_data_in),
            .i_push_id    (w_push_id),
            .i_prev_valid (w_prev_valid),
            .i_prev_hit   (w_prev_hit),
            .i_prev_first (w_prev_first),
            .i_next_valid (w_next_valid),
            .i_next_id    (w_next_id),
            .i_next_data  (w_next_data),
            .o_valid      (w_valid[g]),
            .o_id         (w_id[g]),
            .o_data       (w_data[g]),
            .o_hit        (w_hit[g]),
            .o_first      (w_first[g]),
            .o_report     (w_report[g])
        );
    end

    always_comb begin
        w_sel_id   = '0;
        w_sel_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_sel_id   = w_sel_id   | (w_id[i]   & {ID_BITS{w_report[i]}});
            w_sel_data = w_sel_data | (w_data[i] & {DATA_BITS{w_report[i]}});
        end
    end

    assign w_found = |w_report;

    always_comb begin
        n_status   = ST_OK;
        n_id_out   = '0;
        n_data_out = '0;
        unique case (w_op)
            OP_PUSH: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_id_out = n_id_ctr;
                end
            end
            OP_PUSH_ID: begin
                n_id_out = i_id_in;
                n_status = w_full ? ST_FULL : ST_OK;
            end
            OP_PEEK, OP_POP_FIRST, OP_POP_LAST, OP_NEXT, OP_DEL_ID, OP_DEL_DATA: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (!w_found) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    n_id_out   = w_sel_id;
                    n_data_out = w_sel_data;
                end
            end
            OP_MODIFY, OP_SEARCH: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (!w_found) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    n_id_out   = i_id_in;
                    n_data_out = (w_op == OP_SEARCH) ? w_sel_data : '0;
                end
            end
            default: n_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_id_ctr    <= '0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept && w_op == OP_PUSH && !w_full) begin
                r_id_ctr <= n_id_ctr;
            end
        end
        if (w_accept) begin
            r_status   <= n_status;
            r_id_out   <= n_id_out;
            r_data_out <= n_data_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_id_out    = r_id_out;
    assign o_data_out  = r_data_out;

    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + CAPACITY'(1))) == '0)
        else $error("table slots not packed from the head");

    a_report_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_report))
        else $error("more than one slot selected for the result");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == OP_PUSH || w_op == OP_PUSH_ID) && !w_full) |=>
        ($countones(w_valid) == $countones($past(w_valid)) + 1))
        else $error("push did not add exactly one entry");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == OP_CLEAR) |=> (w_valid == '0))
        else $error("clear left entries in the table");

endmodule

// ===== rtl/core/koqt_cell.sv =====
// One slot of the ordered table: valid flag, id and data handle.
// Matches against the broadcast key, ripples the first-hit flag toward the
// tail and takes its neighbor's content when it or an earlier slot is removed.
// Depends on koqt_pkg.
module koqt_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  koqt_pkg::t_ctrl                  i_ctrl,
    input  logic [koqt_pkg::ID_BITS-1:0]     i_key_id,
    input  logic [koqt_pkg::DATA_BITS-1:0]   i_key_data,
    input  logic [koqt_pkg::ID_BITS-1:0]     i_push_id,
    input  logic                             i_prev_valid,
    input  logic                             i_prev_hit,
    input  logic                             i_prev_first,
    input  logic                             i_next_valid,
    input  logic [koqt_pkg::ID_BITS-1:0]     i_next_id,
    input  logic [koqt_pkg::DATA_BITS-1:0]   i_next_data,
    output logic                             o_valid,
    output logic [koqt_pkg::ID_BITS-1:0]     o_id,
    output logic [koqt_pkg::DATA_BITS-1:0]   o_data,
    output logic                             o_hit,
    output logic                             o_first,
    output logic                             o_report
);
    import koqt_pkg::*;

    logic                 r_valid;
    logic [ID_BITS-1:0]   r_id;
    logic [DATA_BITS-1:0] r_data;
    logic                 n_valid;
    logic [ID_BITS-1:0]   n_id;
    logic [DATA_BITS-1:0] n_data;
    logic                 w_match;

    assign w_match = r_valid & (i_ctrl.match_all
                     | (i_ctrl.match_id   & (r_id == i_key_id))
                     | (i_ctrl.match_data & (r_data == i_key_data))
                     | (i_ctrl.match_tail & !i_next_valid));

    assign o_first  = w_match & !i_prev_hit;
    assign o_hit    = i_prev_hit | w_match;
    assign o_report = i_ctrl.report_next ? (i_prev_first & r_valid) : o_first;
    assign o_valid  = r_valid;
    assign o_id     = r_id;
    assign o_data   = r_data;

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_data  = r_data;
        if (i_ctrl.en) begin
            if (i_ctrl.do_clear) begin
                n_valid = 1'b0;
            end else if (i_ctrl.do_push && !r_valid && i_prev_valid) begin
                n_valid = 1'b1;
                n_id    = i_push_id;
                n_data  = i_key_data;
            end else if (i_ctrl.do_remove && o_hit) begin
                n_valid = i_next_valid;
                n_id    = i_next_id;
                n_data  = i_next_data;
            end else if (i_ctrl.do_modify && o_first) begin
                n_data  = i_key_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_id   <= n_id;
        r_data <= n_data;
    end

endmodule

// ===== bench/tb_keyed_ordered_queue_table.sv =====
`timescale 1ns / 1ps
// Self-checking bench for keyed_ordered_queue_table: directed and random operations
// checked beat by beat against a mirror of the ordered table. Depends on koqt_pkg and keyed_ordered_queue_table.
module tb_keyed_ordered_queue_table;
    import koqt_pkg::*;

    localparam logic [OP_BITS-1:0] OP_UNUSED_LO    = 4'd11;
    localparam logic [OP_BITS-1:0] OP_UNUSED_HI    = 4'd15;
    localparam int                 WATCHDOG_CYCLES = 2000;
    localparam int                 FILL_ROUNDS     = 8;
    localparam int                 MIX_BEATS       = 780;

    typedef struct packed {
        logic [OP_BITS-1:0]   op;
        logic [ID_BITS-1:0]   id;
        logic [DATA_BITS-1:0] data;
        logic                 from_start;
    } t_beat;

    typedef struct packed {
        t_status              status;
        logic [ID_BITS-1:0]   id;
        logic [DATA_BITS-1:0] data;
    } t_reply;

    typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_SPARSE} t_rx_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [OP_BITS-1:0]   i_opcode;
    logic [ID_BITS-1:0]   i_id_in;
    logic [DATA_BITS-1:0] i_data_in;
    logic                 i_from_start;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [ST_BITS-1:0]   o_status;
    logic [ID_BITS-1:0]   o_id_out;
    logic [DATA_BITS-1:0] o_data_out;

    logic [ID_BITS-1:0]   mirror_id   [CAPACITY];
    logic [DATA_BITS-1:0] mirror_data [CAPACITY];
    int                   mirror_count = 0;
    logic [ID_BITS-1:0]   mirror_ctr   = '0;
    t_reply               queued_replies [$];

    int mismatches      = 0;
    int beats_in        = 0;
    int replies_checked = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int burst_left      = 0;
    bit steady_tx       = 1'b0;

    keyed_ordered_queue_table u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_id_in      (i_id_in),
        .i_data_in    (i_data_in),
        .i_from_start (i_from_start),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_id_out     (o_id_out),
        .o_data_out   (o_data_out)
    );

    always #6 i_clk = ~i_clk;

    function automatic int find_id(input logic [ID_BITS-1:0] key);
        for (int i = 0; i < mirror_count; i++) begin
            if (mirror_id[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic int find_data(input logic [DATA_BITS-1:0] key);
        for (int i = 0; i < mirror_count; i++) begin
            if (mirror_data[i] == key) return i;
        end
        return -1;
    endfunction

    task automatic mirror_append(input logic [ID_BITS-1:0] id, input logic [DATA_BITS-1:0] data);
        mirror_id[mirror_count]   = id;
        mirror_data[mirror_count] = data;
        mirror_count++;
    endtask

    task automatic mirror_remove(input int pos);
        for (int i = pos; i < mirror_count - 1; i++) begin
            mirror_id[i]   = mirror_id[i + 1];
            mirror_data[i] = mirror_data[i + 1];
        end
        mirror_count--;
    endtask

    task automatic apply_table_op(input t_beat b, output t_reply r);
        int pos;
        r.status = ST_OK;
        r.id     = '0;
        r.data   = '0;
        case (b.op)
            OP_PUSH: begin
                if (mirror_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    mirror_ctr = mirror_ctr + 1'b1;
                    mirror_append(mirror_ctr, b.data);
                    r.id = mirror_ctr;
                end
            end
            OP_PUSH_ID: begin
                r.id = b.id;
                if (mirror_count >= CAPACITY) r.status = ST_FULL;
                else mirror_append(b.id, b.data);
            end
            OP_PEEK, OP_POP_FIRST, OP_POP_LAST: begin
                if (mirror_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos    = (b.op == OP_POP_LAST) ? mirror_count - 1 : 0;
                    r.id   = mirror_id[pos];
                    r.data = mirror_data[pos];
                    if (b.op != OP_PEEK) mirror_remove(pos);
                end
            end
            OP_NEXT: begin
                if (mirror_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (b.from_start) begin
                        pos = 0;
                    end else begin
                        pos = find_data(b.data);
                        pos = (pos < 0 || pos + 1 >= mirror_count) ? -1 : pos + 1;
                    end
                    if (pos < 0) begin
                        r.status = ST_NOTFOUND;
                    end else begin
                        r.id   = mirror_id[pos];
                        r.data = mirror_data[pos];
                    end
                end
            end
            OP_DEL_ID, OP_DEL_DATA: begin
                if (mirror_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos = (b.op == OP_DEL_ID) ? find_id(b.id) : find_data(b.data);
                    if (pos < 0) begin
                        r.status = ST_NOTFOUND;
                    end else begin
                        r.id   = mirror_id[pos];
                        r.data = mirror_data[pos];
                        mirror_remove(pos);
                    end
                end
            end
            OP_MODIFY, OP_SEARCH: begin
                if (mirror_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos = find_id(b.id);
                    if (pos < 0) begin
                        r.status = ST_NOTFOUND;
                    end else begin
                        r.id = b.id;
                        if (b.op == OP_MODIFY) mirror_data[pos] = b.data;
                        else r.data = mirror_data[pos];
                    end
                end
            end
            OP_CLEAR: begin
                mirror_count = 0;
            end
            default: begin
            end
        endcase
        status_seen[r.status]++;
    endtask

    always @(posedge i_clk) begin : check_replies
        t_beat  beat;
        t_reply want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                replies_checked++;
                if (queued_replies.size() == 0) begin
                    $error("reply beat with nothing outstanding: status %0d id %0h data %0h",
                           o_status, o_id_out, o_data_out);
                    mismatches++;
                end else begin
                    want = queued_replies.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        mismatches++;
                    end
                    if (o_id_out !== want.id) begin
                        $error("id_out: expected %0h, got %0h", want.id, o_id_out);
                        mismatches++;
                    end
                    if (o_data_out !== want.data) begin
                        $error("data_out: expected %0h, got %0h", want.data, o_data_out);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                beat = '{i_opcode, i_id_in, i_data_in, i_from_start};
                apply_table_op(beat, want);
                queued_replies.push_back(want);
                beats_in++;
            end
        end
    end

    initial begin : rx_stall
        t_rx_mode rx_mode;
        int       rx_left;
        int       rx_phase;
        rx_mode     = RX_OPEN;
        rx_left     = 0;
        rx_phase    = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 120);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
                RX_OPEN:         i_out_ready <= 1'b1;
                RX_COIN:         i_out_ready <= 1'($urandom_range(0, 1));
                RX_EVERY_FOURTH: i_out_ready <= (rx_phase % 4) == 0;
                default:         i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end
        $error("no beat accepted for %0d cycles", WATCHDOG_CYCLES);
        $display("tb_keyed_ordered_queue_table: FAIL");
        $finish;
    end

    task automatic send_beat(input logic [OP_BITS-1:0] op, input logic [ID_BITS-1:0] id,
                             input logic [DATA_BITS-1:0] data, input logic start);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = (steady_tx || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_id_in      <= id;
        i_data_in    <= data;
        i_from_start <= start;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        burst_left--;
    endtask

    function automatic logic [DATA_BITS-1:0] any_data();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return DATA_BITS'($urandom_range(0, 7));
            default: return DATA_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [ID_BITS-1:0] pick_id();
        if (mirror_count != 0 && $urandom_range(0, 3) != 0)
            return mirror_id[$urandom_range(0, mirror_count - 1)];
        return ID_BITS'($urandom);
    endfunction

    function automatic logic [DATA_BITS-1:0] pick_data();
        if (mirror_count != 0 && $urandom_range(0, 3) != 0)
            return mirror_data[$urandom_range(0, mirror_count - 1)];
        return any_data();
    endfunction

    function automatic logic [ID_BITS-1:0] push_id();
        return ($urandom_range(0, 2) == 0) ? pick_id() : ID_BITS'($urandom);
    endfunction

    function automatic logic [OP_BITS-1:0] pick_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 24) return OP_PUSH;
        if (roll < 34) return OP_PUSH_ID;
        if (roll < 39) return OP_PEEK;
        if (roll < 46) return OP_POP_FIRST;
        if (roll < 52) return OP_POP_LAST;
        if (roll < 62) return OP_NEXT;
        if (roll < 70) return OP_DEL_ID;
        if (roll < 78) return OP_DEL_DATA;
        if (roll < 88) return OP_MODIFY;
        if (roll < 96) return OP_SEARCH;
        if (roll < 98) return OP_CLEAR;
        return OP_BITS'(OP_UNUSED_LO + $urandom_range(0, OP_UNUSED_HI - OP_UNUSED_LO));
    endfunction

    task automatic test_empty_table();
        send_beat(OP_PEEK,      16'h0000, 32'h0000_0000, 1'b0);
        send_beat(OP_POP_FIRST, 16'h0000, 32'h0000_0000, 1'b0);
        send_beat(OP_POP_LAST,  16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_beat(OP_NEXT,      16'h0000, 32'h0000_0000, 1'b1);
        send_beat(OP_DEL_ID,    16'hFFFF, 32'h0000_0000, 1'b0);
        send_beat(OP_DEL_DATA,  16'h0000, 32'h0000_0000, 1'b0);
        send_beat(OP_MODIFY,    16'h0000, 32'hFFFF_FFFF, 1'b0);
        send_beat(OP_SEARCH,    16'h0000, 32'h0000_0000, 1'b0);
    endtask

    task automatic test_unused_opcodes();
        send_beat(OP_UNUSED_LO, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_beat(OP_UNUSED_HI, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_directed_ops();
        send_beat(OP_PUSH,      16'h0000, 32'h0000_0000, 1'b0);
        send_beat(OP_PUSH_ID,   16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        send_beat(OP_PUSH_ID,   16'h0000, 32'h0000_0001, 1'b0);
        send_beat(OP_PUSH_ID,   16'hFFFF, 32'hA5A5_5A5A, 1'b0);
        send_beat(OP_NEXT,      16'h0000, 32'hFFFF_FFFF, 1'b1);
        send_beat(OP_NEXT,      16'h0000, 32'h0000_0000, 1'b0);
        send_beat(OP_NEXT,      16'h0000, 32'hA5A5_5A5A, 1'b0);
        send_beat(OP_NEXT,      16'h0000, 32'h1234_5678, 1'b0);
        send_beat(OP_MODIFY,    16'hFFFF, 32'h0000_00FF, 1'b0);
        send_beat(OP_SEARCH,    16'hFFFF, 32'h0000_0000, 1'b0);
        send_beat(OP_DEL_ID,    16'hFFFF, 32'h0000_0000, 1'b0);
        send_beat(OP_DEL_DATA,  16'h0000, 32'hA5A5_5A5A, 1'b0);
        send_beat(OP_POP_LAST,  16'h0000, 32'h0000_0000, 1'b0);
        send_beat(OP_POP_FIRST, 16'h0000, 32'h0000_0000, 1'b0);
        send_beat(OP_PUSH,      16'h0000, 32'hDEAD_BEEF, 1'b0);
        send_beat(OP_CLEAR,     16'h0000, 32'h0000_0000, 1'b0);
        send_beat(OP_PUSH,      16'h0000, 32'h0BAD_F00D, 1'b0);
    endtask

    task automatic test_fill_drain_rounds();
        logic [OP_BITS-1:0] op;
        for (int round = 0; round < FILL_ROUNDS; round++) begin
            for (int k = 0; k < CAPACITY + 3; k++) begin
                if ($urandom_range(0, 2) == 0)
                    send_beat(OP_PUSH_ID, push_id(), any_data(), 1'($urandom_range(0, 1)));
                else
                    send_beat(OP_PUSH, ID_BITS'($urandom), any_data(), 1'($urandom_range(0, 1)));
            end
            for (int k = 0; k < 6; k++) begin
                case ($urandom_range(0, 2))
                    0:       send_beat(OP_NEXT, pick_id(), pick_data(), $urandom_range(0, 4) == 0);
                    1:       send_beat(OP_SEARCH, pick_id(), any_data(), 1'($urandom_range(0, 1)));
                    default: send_beat(OP_MODIFY, pick_id(), any_data(), 1'($urandom_range(0, 1)));
                endcase
            end
            for (int k = 0; k < CAPACITY + 2; k++) begin
                case ($urandom_range(0, 3))
                    0:       op = OP_POP_FIRST;
                    1:       op = OP_POP_LAST;
                    2:       op = OP_DEL_ID;
                    default: op = OP_DEL_DATA;
                endcase
                send_beat(op, pick_id(), pick_data(), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_random_mix();
        logic [OP_BITS-1:0]   op;
        logic [ID_BITS-1:0]   id;
        logic [DATA_BITS-1:0] data;
        logic                 start;
        for (int k = 0; k < MIX_BEATS; k++) begin
            steady_tx = (k >= 300 && k < 450);
            op    = pick_op();
            id    = (op == OP_PUSH_ID) ? push_id() : pick_id();
            data  = (op == OP_NEXT || op == OP_DEL_DATA) ? pick_data() : any_data();
            start = (op == OP_NEXT) ? ($urandom_range(0, 4) == 0) : 1'($urandom_range(0, 1));
            send_beat(op, id, data, start);
        end
        steady_tx = 1'b0;
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_opcode     <= OP_PUSH;
        i_id_in      <= '0;
        i_data_in    <= '0;
        i_from_start <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_unused_opcodes();
        test_directed_ops();
        test_fill_drain_rounds();
        test_random_mix();

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (queued_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Ran %0d operations, %0d replies checked (ok %0d, empty %0d, not found %0d, full %0d).",
                 beats_in, replies_checked, status_seen[ST_OK], status_seen[ST_EMPTY],
                 status_seen[ST_NOTFOUND], status_seen[ST_FULL]);
        if (mismatches == 0) begin
            $display("tb_keyed_ordered_queue_table: PASS");
        end else begin
            $display("tb_keyed_ordered_queue_table: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/koqt_pkg.sv
rtl/core/koqt_cell.sv
rtl/core/keyed_ordered_queue_table.sv
bench/tb_keyed_ordered_queue_table.sv
